@@ sv/rlsm_pkg.sv @@
// Package for the row log-softmax unit: exp and ln tables, widths.
// No dependencies.
package rlsm_pkg;
  localparam int SCORE_W = 16;
  localparam int CFG_W   = 6;
  localparam int SUM_W   = 32;
  localparam logic [15:0] LN2_Q16 = 16'd45426;

  function automatic logic [16:0] e_int(input logic [3:0] i);
    case (i)
      4'd0: e_int = 17'd65536;
      4'd1: e_int = 17'd24109;
      4'd2: e_int = 17'd8869;
      4'd3: e_int = 17'd3263;
      4'd4: e_int = 17'd1200;
      4'd5: e_int = 17'd442;
      4'd6: e_int = 17'd162;
      4'd7: e_int = 17'd60;
      4'd8: e_int = 17'd22;
      4'd9: e_int = 17'd8;
      4'd10: e_int = 17'd3;
      4'd11: e_int = 17'd1;
      default: e_int = 17'd0;
    endcase
  endfunction

  function automatic logic [16:0] e_hi(input logic [3:0] i);
    case (i)
      4'd0: e_hi = 17'd65536;
      4'd1: e_hi = 17'd61565;
      4'd2: e_hi = 17'd57835;
      4'd3: e_hi = 17'd54331;
      4'd4: e_hi = 17'd51039;
      4'd5: e_hi = 17'd47947;
      4'd6: e_hi = 17'd45042;
      4'd7: e_hi = 17'd42313;
      4'd8: e_hi = 17'd39750;
      4'd9: e_hi = 17'd37341;
      4'd10: e_hi = 17'd35079;
      4'd11: e_hi = 17'd32954;
      4'd12: e_hi = 17'd30957;
      4'd13: e_hi = 17'd29081;
      4'd14: e_hi = 17'd27320;
      default: e_hi = 17'd25664;
    endcase
  endfunction

  function automatic logic [16:0] e_lo(input logic [3:0] i);
    case (i)
      4'd0: e_lo = 17'd65536;
      4'd1: e_lo = 17'd65280;
      4'd2: e_lo = 17'd65026;
      4'd3: e_lo = 17'd64772;
      4'd4: e_lo = 17'd64520;
      4'd5: e_lo = 17'd64268;
      4'd6: e_lo = 17'd64018;
      4'd7: e_lo = 17'd63768;
      4'd8: e_lo = 17'd63520;
      4'd9: e_lo = 17'd63272;
      4'd10: e_lo = 17'd63025;
      4'd11: e_lo = 17'd62780;
      4'd12: e_lo = 17'd62535;
      4'd13: e_lo = 17'd62291;
      4'd14: e_lo = 17'd62048;
      default: e_lo = 17'd61806;
    endcase
  endfunction

  function automatic logic [15:0] ln_tab(input logic [4:0] i);
    case (i)
      5'd0: ln_tab = 16'd0;
      5'd1: ln_tab = 16'd3973;
      5'd2: ln_tab = 16'd7719;
      5'd3: ln_tab = 16'd11262;
      5'd4: ln_tab = 16'd14624;
      5'd5: ln_tab = 16'd17821;
      5'd6: ln_tab = 16'd20870;
      5'd7: ln_tab = 16'd23783;
      5'd8: ln_tab = 16'd26573;
      5'd9: ln_tab = 16'd29248;
      5'd10: ln_tab = 16'd31818;
      5'd11: ln_tab = 16'd34292;
      5'd12: ln_tab = 16'd36675;
      5'd13: ln_tab = 16'd38975;
      5'd14: ln_tab = 16'd41197;
      5'd15: ln_tab = 16'd43345;
      default: ln_tab = 16'd45426;
    endcase
  endfunction
endpackage

@@ sv/rlsm_exp.sv @@
// Pipelined table exponential exp(-d), Q1.16 result, three stages.
// Depends on rlsm_pkg.
module rlsm_exp #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        in_vld,
  input  logic [16:0] d,
  output logic        out_vld,
  output logic [16:0] e
);
  import rlsm_pkg::*;
  localparam int IW = 17 - FRAC_BITS;

  logic [IW-1:0] ip;
  logic [FRAC_BITS-1:0] fp;
  logic [7:0] f8;
  logic [16:0] a_int, a_hi;
  logic [3:0] lo_idx, lo_idx_q;
  logic zero;
  logic [33:0] p1;
  logic [16:0] e1;
  logic v1, v2;
  logic [33:0] p3;

  assign ip = d[16:FRAC_BITS];
  assign fp = d[FRAC_BITS-1:0];
  if (FRAC_BITS >= 8) begin : g_sh
    assign f8 = fp[FRAC_BITS-1 -: 8];
  end else begin : g_ex
    assign f8 = {fp, {(8-FRAC_BITS){1'b0}}};
  end
  assign zero = (ip >= IW'(12));

  always_ff @(posedge clk) begin
    v1 <= in_vld;
    a_int <= zero ? 17'd0 : e_int(ip[3:0]);
    a_hi <= e_hi(f8[7:4]);
    lo_idx <= f8[3:0];
    v2 <= v1;
    p1 <= a_int * a_hi + 34'd32768;
    lo_idx_q <= lo_idx;
  end

  assign e1 = p1[32:16];
  assign p3 = e1 * e_lo(lo_idx_q) + 34'd32768;
  always_ff @(posedge clk) begin
    out_vld <= v2;
    e <= p3[32:16];
  end
endmodule

@@ sv/rlsm_ln.sv @@
// Iterative leading-one search plus table ln, rounded offset in score LSBs.
// Depends on rlsm_pkg.
module rlsm_ln #(
  parameter int FRAC_BITS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] sum,
  output logic        done,
  output logic [15:0] off
);
  import rlsm_pkg::*;
  localparam logic [1:0] S_IDLE = 2'd0, S_SRCH = 2'd1, S_TAB = 2'd2, S_FIN = 2'd3;

  logic [1:0] st;
  logic [31:0] val;
  logic [3:0] sh;
  logic [19:0] acc;
  logic [15:0] lo, hi;
  logic [27:0] prod;
  logic [20:0] tot;

  assign lo = ln_tab({1'b0, val[30:27]});
  assign hi = ln_tab({1'b0, val[30:27]} + 5'd1);
  assign prod = (hi - lo) * val[26:15];
  assign tot = {1'b0, acc} + 21'(lo) + 21'(prod[27:12]) + 21'(1 << (15 - FRAC_BITS));

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      case (st)
        S_IDLE: begin
          if (start) begin
            val <= sum;
            sh <= 4'd15;
            acc <= 20'(16'd15 * LN2_Q16);
            st <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (val[31] || sh == 4'd0) begin
            st <= S_TAB;
          end else begin
            val <= val << 1;
            sh <= sh - 4'd1;
            acc <= acc - 20'(LN2_Q16);
          end
        end
        S_TAB: begin
          off <= 16'(tot >> (16 - FRAC_BITS));
          st <= S_FIN;
        end
        S_FIN: begin
          done <= 1'b1;
          st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

@@ sv/row_log_softmax_unit.sv @@
// Row log-softmax: loads a row into a registered-read memory, sums exp, takes ln,
// then replays the row. Input: scores are taken only in S_LOAD; in_stall is high
// otherwise. One memory read port, reused by both passes (exp and output).
// rst (synchronous) clears count, max, length 31.
module row_log_softmax_unit #(
  parameter int MAX_CLASSES = 32,
  parameter int FRAC_BITS   = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [5:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] score,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] log_prob,
  output logic        row_last
);
  import rlsm_pkg::*;
  localparam int AW = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
  localparam int CW = $clog2(MAX_CLASSES + 1);
  localparam logic [2:0] S_LOAD = 3'd0, S_EXP = 3'd1, S_DRAIN = 3'd2,
                         S_LN = 3'd3, S_OUT = 3'd4;

  logic [2:0] st;
  logic [5:0] num_classes;
  logic [CW-1:0] cnt, rd_idx, n_eff;
  logic signed [15:0] row_max;
  logic [31:0] exp_sum;
  logic signed [15:0] mem [MAX_CLASSES];
  logic signed [15:0] rd_data;
  logic rd_en, rd_v, rd_last;
  logic [4:0] drain;
  logic ev;
  logic [16:0] ed, ee;
  logic ev_o;
  logic ln_start, ln_done;
  logic [15:0] off;
  logic full;

  always_comb begin
    if (num_classes == 6'd0) n_eff = CW'(1);
    else if (32'(num_classes) > MAX_CLASSES) n_eff = CW'(MAX_CLASSES);
    else n_eff = CW'(num_classes);
  end

  assign in_stall = (st != S_LOAD);
  assign full = (cnt >= CW'(MAX_CLASSES));

  logic out_hold;
  assign out_hold = out_valid && out_stall;
  assign rd_en = ((st == S_EXP) || (st == S_OUT && !out_hold)) && (rd_idx < cnt);

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall && !full) mem[cnt[AW-1:0]] <= score;
    if (rd_en) rd_data <= mem[rd_idx[AW-1:0]];
  end

  rlsm_exp #(.FRAC_BITS(FRAC_BITS)) u_exp (
    .clk(clk), .in_vld(ev), .d(ed), .out_vld(ev_o), .e(ee));
  assign ev = rd_v && (st == S_EXP || st == S_DRAIN);
  assign ed = 17'({row_max[15], row_max} - {rd_data[15], rd_data});

  assign ln_start = (st == S_DRAIN) && (drain == 5'd0);
  rlsm_ln #(.FRAC_BITS(FRAC_BITS)) u_ln (
    .clk(clk), .rst(rst), .start(ln_start),
    .sum((exp_sum < 32'd65536) ? 32'd65536 : exp_sum),
    .done(ln_done), .off(off));

  logic signed [17:0] v;
  assign v = 18'(rd_data) - 18'(row_max) - 18'({2'b00, off});

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_LOAD;
      num_classes <= 6'd31;
      cnt <= '0;
      row_max <= 16'sh8000;
      exp_sum <= '0;
      rd_v <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) num_classes <= cfg_wdata;
      if (ev_o) exp_sum <= exp_sum + 32'(ee);
      case (st)
        S_LOAD: begin
          rd_v <= 1'b0;
          if (in_valid) begin
            if (!full) cnt <= cnt + CW'(1);
            if (score > row_max) row_max <= score;
            if ((full ? cnt : cnt + CW'(1)) >= n_eff) begin
              st <= S_EXP;
              rd_idx <= '0;
              exp_sum <= '0;
            end
          end
        end
        S_EXP: begin
          rd_v <= rd_en;
          rd_idx <= rd_idx + CW'(1);
          if (!rd_en) begin
            st <= S_DRAIN;
            drain <= 5'd6;
          end
        end
        S_DRAIN: begin
          rd_v <= 1'b0;
          if (drain != 5'd0) drain <= drain - 5'd1;
          else st <= S_LN;
        end
        S_LN: begin
          if (ln_done) begin
            st <= S_OUT;
            rd_idx <= '0;
          end
        end
        S_OUT: begin
          if (!out_hold) begin
            rd_v <= rd_en;
            rd_last <= rd_en && (rd_idx + CW'(1) == cnt);
            if (rd_en) rd_idx <= rd_idx + CW'(1);
            out_valid <= rd_v;
            if (rd_v) begin
              log_prob <= (v < -18'sd32768) ? 16'sh8000 : v[15:0];
              row_last <= rd_last;
            end
            if (out_valid && row_last) begin
              st <= S_LOAD;
              cnt <= '0;
              row_max <= 16'sh8000;
              exp_sum <= '0;
            end
          end
        end
        default: st <= S_LOAD;
      endcase
    end
  end

  a_stall_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> st == S_OUT || st == S_LOAD) else $error("beat outside output pass");
  a_no_in: assert property (@(posedge clk) disable iff (rst)
    st != S_LOAD |-> in_stall) else $error("input taken while busy");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(MAX_CLASSES)) else $error("count overflow");
endmodule

@@ verif/row_log_softmax_unit_test.sv @@
// Testbench for row_log_softmax_unit: directed table then random rows, checked
// against an in-bench fixed-point log-softmax predictor. Depends on rlsm_pkg.
`timescale 1ns / 100ps

module row_log_softmax_unit_test;
  import rlsm_pkg::*;

  localparam int MAXC = 32;
  localparam int WATCHDOG = 20000;

  typedef struct packed {
    logic signed [15:0] log_prob;
    logic               row_last;
  } prob_t;

  typedef struct {
    logic        is_cfg;
    logic [5:0]  cfg;
    logic [15:0] score;
    logic        chk;
    logic [15:0] exp_lp;
    logic        exp_last;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [5:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] score = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] log_prob;
  logic row_last;

  always #4 clk = ~clk;

  row_log_softmax_unit dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .score(score),
    .out_valid(out_valid), .out_stall(out_stall), .log_prob(log_prob),
    .row_last(row_last)
  );

  // predictor state
  logic signed [15:0] row_buf [MAXC];
  logic signed [15:0] cur_max;
  int unsigned        cur_cnt;
  logic [5:0]         row_len;
  prob_t              pending [$];
  logic               fixed_chk [$];
  prob_t              fixed_val [$];

  int  errors = 0;
  int  idle_cnt = 0;
  bit  quiet = 1'b0;
  bit  hold_long = 1'b0;
  bit  in_free = 1'b0;

  function automatic logic [31:0] exp_term(logic [15:0] d);
    logic [7:0] ip;
    logic [7:0] f8;
    logic [63:0] e;
    ip = d[15:8];
    f8 = d[7:0];
    if (ip >= 12) return 32'd0;
    e = (64'(e_int(ip[3:0])) * e_hi(f8[7:4]) + 32768) >> 16;
    e = (e * e_lo(f8[3:0]) + 32768) >> 16;
    return e[31:0];
  endfunction

  function automatic logic [31:0] ln_fix(logic [31:0] s);
    int p;
    logic [31:0] fr, lo, hi;
    p = 16;
    while (p < 31 && (s >> (p + 1)) != 0) p++;
    fr = ((s - (32'd1 << p)) >> (p - 16)) & 32'hFFFF;
    lo = ln_tab(5'(fr >> 12));
    hi = ln_tab(5'((fr >> 12) + 1));
    return (p - 16) * LN2_Q16 + lo + (((hi - lo) * (fr & 32'hFFF)) >> 12);
  endfunction

  task automatic predict_score(logic signed [15:0] s);
    int unsigned n;
    logic [31:0] sum, off;
    int lsb, v;
    prob_t r;
    n = row_len == 0 ? 1 : (row_len > MAXC ? MAXC : row_len);
    if (cur_cnt < MAXC) begin
      row_buf[cur_cnt] = s;
      cur_cnt++;
    end
    if (s > cur_max) cur_max = s;
    if (cur_cnt < n) return;
    sum = 0;
    for (int k = 0; k < cur_cnt; k++)
      sum += exp_term(16'(32'(cur_max) - 32'(row_buf[k])));
    if (sum < 32'd65536) sum = 32'd65536;
    off = ln_fix(sum);
    lsb = int'((off + 32'd128) >> 8);
    for (int k = 0; k < cur_cnt; k++) begin
      v = int'(row_buf[k]) - int'(cur_max) - lsb;
      if (v < -32768) v = -32768;
      r.log_prob = 16'(v);
      r.row_last = (k + 1 == cur_cnt);
      pending.insert(pending.size(), r);
    end
    cur_cnt = 0;
    cur_max = 16'sh8000;
  endtask

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // result check
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending.size() == 0) begin
        $error("unexpected beat log_prob=%0d row_last=%0b", log_prob, row_last);
        errors++;
      end else begin
        prob_t e;
        e = pending.pop_front();
        if (fixed_chk.size() != 0) begin
          if (fixed_chk.pop_front()) e = fixed_val.pop_front();
          else void'(fixed_val.pop_front());
        end
        if (log_prob !== e.log_prob) begin
          $error("log_prob expected %0d actual %0d", e.log_prob, log_prob);
          errors++;
        end
        if (row_last !== e.row_last) begin
          $error("row_last expected %0b actual %0b", e.row_last, row_last);
          errors++;
        end
      end
    end
  end

  // receiver stalls
  initial begin
    int gap;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk);
        out_stall <= 1'b0;
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 13);
        out_stall <= 1'b1;
        repeat (gap - 1) @(posedge clk);
        @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send(logic [15:0] s);
    in_valid <= 1'b1;
    score <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_score(s);
    if (!quiet && !in_free && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic drain_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_len(logic [5:0] v);
    drain_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    row_len = v;
  endtask

  function automatic logic [15:0] rand_score(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 2047) - 1024);
      default: return 16'($urandom_range(0, 511) + 16'h4000);
    endcase
  endfunction

  vec_t table_v [$];

  task automatic add_row(logic [15:0] s, logic c = 0, logic [15:0] lp = 0, logic l = 0);
    vec_t v;
    v.is_cfg = 0; v.cfg = 0; v.score = s; v.chk = c; v.exp_lp = lp; v.exp_last = l;
    table_v.insert(table_v.size(), v);
  endtask

  task automatic add_cfg(logic [5:0] n);
    vec_t v;
    v.is_cfg = 1; v.cfg = n; v.score = 0; v.chk = 0; v.exp_lp = 0; v.exp_last = 0;
    table_v.insert(table_v.size(), v);
  endtask

  initial begin
    int mode, n, rows;
    for (int k = 0; k < MAXC; k++) row_buf[k] = '0;
    cur_max = 16'sh8000;
    cur_cnt = 0;
    row_len = 6'd31;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: single-score rows give log_prob 0, a 7FFF/8000 row saturates to 8000
    add_cfg(6'd1);
    add_row(16'h7FFF, 1, 16'h0000, 1);
    add_row(16'h8000, 1, 16'h0000, 1);
    add_cfg(6'd0);
    add_row(16'h0000, 1, 16'h0000, 1);
    add_cfg(6'd2);
    add_row(16'h7FFF);
    add_row(16'h8000, 1, 16'h8000, 1);
    add_row(16'h0100);
    add_row(16'h0100);
    add_cfg(6'd63);
    for (int k = 0; k < 3; k++) add_row(16'(k * 77));
    add_cfg(6'd2);
    add_row(16'hFF00);
    add_cfg(6'd32);
    for (int k = 0; k < 8; k++) add_row(16'(k << 6));
    foreach (table_v[i]) begin
      if (table_v[i].is_cfg) write_len(table_v[i].cfg);
      else begin
        prob_t f;
        f.log_prob = table_v[i].exp_lp;
        f.row_last = table_v[i].exp_last;
        // fixed expectations line up with the predictor's queue position
        while (fixed_chk.size() < pending.size()) begin
          fixed_chk.insert(fixed_chk.size(), 1'b0);
          fixed_val.insert(fixed_val.size(), f);
        end
        send(table_v[i].score);
        if (table_v[i].chk) begin
          while (fixed_chk.size() < pending.size() - 1) begin
            fixed_chk.insert(fixed_chk.size(), 1'b0);
            fixed_val.insert(fixed_val.size(), f);
          end
          if (fixed_chk.size() < pending.size()) begin
            fixed_chk.insert(fixed_chk.size(), 1'b1);
            fixed_val.insert(fixed_val.size(), f);
          end
        end
      end
    end
    drain_idle();
    fixed_chk.delete();
    fixed_val.delete();

    // long receiver hold while sender keeps offering
    write_len(6'd4);
    hold_long = 1'b1;
    in_free = 1'b1;
    for (int k = 0; k < 24; k++) send(rand_score(0));
    in_free = 1'b0;
    drain_idle();

    rows = 0;
    n = 0;
    while (n < 330) begin
      if (rows % 6 == 0) begin
        case ($urandom_range(0, 5))
          0: write_len(6'd1);
          1: write_len(6'd32);
          2: write_len(6'($urandom_range(33, 63)));
          default: write_len(6'($urandom_range(2, 12)));
        endcase
      end
      if (n > 280) quiet = 1'b1;
      mode = $urandom_range(0, 2);
      for (int k = 0; k < (row_len == 0 ? 1 : (row_len > 32 ? 32 : row_len)); k++) begin
        send(rand_score(mode));
        n++;
      end
      rows++;
    end
    // length lowered mid-row
    write_len(6'd8);
    for (int k = 0; k < 5; k++) send(rand_score(1));
    write_len(6'd3);
    send(rand_score(1));
    drain_idle();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

@@ files.f @@
sv/rlsm_pkg.sv
sv/rlsm_exp.sv
sv/rlsm_ln.sv
sv/row_log_softmax_unit.sv
verif/row_log_softmax_unit_test.sv
